// File: src/ipfi_pkg.sv
// ----------------------------------------------------------------------------
// ipfi_pkg
// Shared types and constants of the integer plane find-or-insert block.
// ----------------------------------------------------------------------------
`default_nettype none
package ipfi_pkg;

	localparam int NormBits = 36;
	localparam int IdxBits  = 10;

	typedef enum logic [1:0] {
		ST_FOUND      = 2'd0,
		ST_INSERTED   = 2'd1,
		ST_DEGENERATE = 2'd2,
		ST_FULL       = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CROSS,
		S_GCD,
		S_DIV,
		S_SEARCH,
		S_CHECK,
		S_WR0,
		S_WR1,
		S_OUT
	} state_t;

endpackage
`default_nettype wire

// File: src/integer_plane_find_or_insert.sv
// ----------------------------------------------------------------------------
// integer_plane_find_or_insert
// Finds the plane through three points in a table, or appends it with its twin.
// ----------------------------------------------------------------------------
// One item is worked at a time. An item takes the cross product (on a pair of
// 17-bit multipliers), a Euclidean GCD in two runs whose every modulo step
// runs on the shared bit-serial divider (start, the quotient bits one by one,
// capture and one decision), three exact divisions on the same divider, and
// then a linear search over the filled table entries through one read port of
// the table memory (S_SEARCH reads an entry, S_CHECK forms the dot product).
// A hit returns at once; a miss writes the plane and its twin in the states
// S_WR0 and S_WR1 unless the table is full. Full-range normals can need up to
// about 100 GCD steps. A full table holds 1024 entries by default.
// The table needs no clearing pass after reset.
`default_nettype none
module integer_plane_find_or_insert #(
	parameter int TABLE_DEPTH = 1024,
	parameter int COORD_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] a_x,
	input  wire logic signed [COORD_BITS-1:0] a_y,
	input  wire logic signed [COORD_BITS-1:0] a_z,
	input  wire logic signed [COORD_BITS-1:0] b_x,
	input  wire logic signed [COORD_BITS-1:0] b_y,
	input  wire logic signed [COORD_BITS-1:0] b_z,
	input  wire logic signed [COORD_BITS-1:0] c_x,
	input  wire logic signed [COORD_BITS-1:0] c_y,
	input  wire logic signed [COORD_BITS-1:0] c_z,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [ipfi_pkg::IdxBits-1:0]      plane_index,
	output logic [1:0]                        status,
	output logic signed [ipfi_pkg::NormBits-1:0] reduced_nx,
	output logic signed [ipfi_pkg::NormBits-1:0] reduced_ny,
	output logic signed [ipfi_pkg::NormBits-1:0] reduced_nz
);

	localparam int NB  = ipfi_pkg::NormBits;
	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int CNT = $clog2(TABLE_DEPTH + 1);
	localparam int DB  = COORD_BITS + 1;
	localparam int PB  = 2 * DB;
	localparam int EB  = DB + NB + 2;
	localparam int RW  = 3 * NB + 3 * COORD_BITS;

	ipfi_pkg::state_t state_q, state_d;

	logic signed [COORD_BITS-1:0] ax_q, ay_q, az_q;
	logic signed [DB-1:0] u_q [3];
	logic signed [DB-1:0] v_q [3];
	logic signed [NB-1:0] n_q [3];
	logic [1:0]           k_q;
	logic [NB-1:0]        ga_q, gb_q;
	logic                 gcd_phase_q;
	logic                 div_go_q;
	logic                 dv_busy_q;
	logic [CNT-1:0]       used_q;
	logic [CNT-1:0]       i_q;
	logic [ipfi_pkg::IdxBits-1:0] idx_q;
	ipfi_pkg::status_t    st_q;
	logic                 first_neg_q;
	logic                 out_valid_q;

	// Cross product terms: each component is the difference of two products.
	logic signed [DB-1:0] m1a, m1b, m2a, m2b;
	logic signed [PB-1:0] p1, p2;
	always_comb begin
		unique case (k_q)
			2'd0: begin m1a = u_q[1]; m1b = v_q[2]; m2a = u_q[2]; m2b = v_q[1]; end
			2'd1: begin m1a = u_q[2]; m1b = v_q[0]; m2a = u_q[0]; m2b = v_q[2]; end
			default: begin m1a = u_q[0]; m1b = v_q[1]; m2a = u_q[1]; m2b = v_q[0]; end
		endcase
	end
	assign p1 = m1a * m1b;
	assign p2 = m2a * m2b;

	function automatic logic [NB-1:0] magn(input logic signed [NB-1:0] x);
		magn = x[NB-1] ? NB'(-x) : x;
	endfunction

	// Shared divider for GCD steps and the final reduction.
	logic          dv_start, dv_busy;
	logic          dv_fin, dv_idle;
	logic [NB-1:0] dv_a, dv_b, dv_qt, dv_rm;
	ipfi_divu #(.W(NB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a),
		.divisor(dv_b), .busy(dv_busy), .quotient(dv_qt), .remainder(dv_rm)
	);
	assign dv_start = div_go_q;
	// The cycle after the last quotient bit captures the result; only after it
	// do the operand registers hold the new pair.
	assign dv_fin   = !dv_busy && dv_busy_q;
	assign dv_idle  = !div_go_q && !dv_busy && !dv_busy_q;
	always_comb begin
		if (state_q == ipfi_pkg::S_GCD) begin
			dv_a = ga_q;
			dv_b = gb_q;
		end else begin
			dv_a = magn(n_q[k_q]);
			dv_b = ga_q;
		end
	end

	// Table memory: one word per entry, normal and origin together.
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [RW-1:0] mem_wdata, mem_rdata;
	logic signed [NB-1:0] wn [3];
	ipfi_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_table (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
	);
	always_comb begin
		logic neg;
		neg = (state_q == ipfi_pkg::S_WR0) ? first_neg_q : !first_neg_q;
		for (int j = 0; j < 3; j++) begin
			wn[j] = neg ? NB'(-n_q[j]) : n_q[j];
		end
	end
	assign mem_we    = (state_q == ipfi_pkg::S_WR0) || (state_q == ipfi_pkg::S_WR1);
	assign mem_addr  = i_q[AW-1:0];
	assign mem_wdata = {wn[0], wn[1], wn[2], ax_q, ay_q, az_q};

	// Dot product of the origin offset with the normal, then the match test.
	logic signed [NB-1:0]         en [3];
	logic signed [COORD_BITS-1:0] eo [3];
	logic signed [EB-1:0]         dot;
	logic                         hit;
	assign {en[0], en[1], en[2], eo[0], eo[1], eo[2]} = mem_rdata;
	always_comb begin
		dot = (EB'(ax_q) - EB'(eo[0])) * EB'(n_q[0])
		    + (EB'(ay_q) - EB'(eo[1])) * EB'(n_q[1])
		    + (EB'(az_q) - EB'(eo[2])) * EB'(n_q[2]);
		hit = (dot == '0) && (en[0] == n_q[0]) && (en[1] == n_q[1])
		    && (en[2] == n_q[2]);
	end

	logic axial_neg;
	always_comb begin
		logic [1:0] nz;
		nz = 2'(n_q[0] != '0) + 2'(n_q[1] != '0) + 2'(n_q[2] != '0);
		axial_neg = (nz == 2'd1) && (n_q[0][NB-1] || n_q[1][NB-1] || n_q[2][NB-1]);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ipfi_pkg::S_IDLE:   if (in_valid) state_d = ipfi_pkg::S_CROSS;
			ipfi_pkg::S_CROSS:  begin
				if (k_q == 2'd2) begin
					state_d = ipfi_pkg::S_GCD;
				end
			end
			ipfi_pkg::S_GCD: begin
				if (n_q[0] == '0 && n_q[1] == '0 && n_q[2] == '0) begin
					state_d = ipfi_pkg::S_OUT;
				end else if (dv_idle && gb_q == '0 && gcd_phase_q) begin
					state_d = ipfi_pkg::S_DIV;
				end
			end
			ipfi_pkg::S_DIV: begin
				if (!div_go_q && !dv_busy && k_q == 2'd3) state_d = ipfi_pkg::S_SEARCH;
			end
			ipfi_pkg::S_SEARCH: begin
				priority if (i_q == used_q) begin
					state_d = (32'(used_q) + 2 > TABLE_DEPTH) ? ipfi_pkg::S_OUT
					                                          : ipfi_pkg::S_WR0;
				end else begin
					state_d = ipfi_pkg::S_CHECK;
				end
			end
			ipfi_pkg::S_CHECK:  state_d = hit ? ipfi_pkg::S_OUT : ipfi_pkg::S_SEARCH;
			ipfi_pkg::S_WR0:    state_d = ipfi_pkg::S_WR1;
			ipfi_pkg::S_WR1:    state_d = ipfi_pkg::S_OUT;
			ipfi_pkg::S_OUT:    if (!out_stall) state_d = ipfi_pkg::S_IDLE;
			default:            state_d = ipfi_pkg::S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_stall    = (state_q != ipfi_pkg::S_IDLE);
		out_valid   = out_valid_q;
		plane_index = idx_q;
		status      = st_q;
		reduced_nx  = n_q[0];
		reduced_ny  = n_q[1];
		reduced_nz  = n_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ipfi_pkg::S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			div_go_q    <= 1'b0;
			dv_busy_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			div_go_q  <= 1'b0;
			dv_busy_q <= dv_busy;
			if (state_q == ipfi_pkg::S_WR1) used_q <= used_q + CNT'(2);
			if (state_q != ipfi_pkg::S_OUT && state_d == ipfi_pkg::S_OUT) out_valid_q <= 1'b1;
			else if (state_q == ipfi_pkg::S_OUT && !out_stall) out_valid_q <= 1'b0;
			if (state_q == ipfi_pkg::S_GCD && k_q != 2'd3 && dv_idle && gb_q != '0)
				div_go_q <= 1'b1;
			if (state_q == ipfi_pkg::S_GCD && state_d == ipfi_pkg::S_DIV) div_go_q <= 1'b1;
			if (state_q == ipfi_pkg::S_DIV && !div_go_q && !dv_busy && k_q < 2'd2)
				div_go_q <= 1'b1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ipfi_pkg::S_IDLE: begin
				ax_q <= a_x; ay_q <= a_y; az_q <= a_z;
				u_q[0] <= DB'(a_x) - DB'(b_x);
				u_q[1] <= DB'(a_y) - DB'(b_y);
				u_q[2] <= DB'(a_z) - DB'(b_z);
				v_q[0] <= DB'(c_x) - DB'(b_x);
				v_q[1] <= DB'(c_y) - DB'(b_y);
				v_q[2] <= DB'(c_z) - DB'(b_z);
				k_q <= 2'd0;
			end
			ipfi_pkg::S_CROSS: begin
				n_q[k_q] <= NB'(p1) - NB'(p2);
				k_q <= k_q + 2'd1;
				if (k_q == 2'd2) begin
					gcd_phase_q <= 1'b0;
					st_q  <= ipfi_pkg::ST_DEGENERATE;
					idx_q <= '0;
				end
			end
			ipfi_pkg::S_GCD: begin
				// First pair is (|nx|, |ny|), then (g, |nz|).
				if (k_q == 2'd3) begin
					ga_q <= magn(n_q[0]);
					gb_q <= magn(n_q[1]);
					k_q  <= 2'd0;
				end else if (dv_idle && gb_q == '0 && !gcd_phase_q) begin
					gb_q <= magn(n_q[2]);
					gcd_phase_q <= 1'b1;
				end else if (div_go_q) begin
					ga_q <= gb_q;
				end else if (dv_fin) begin
					gb_q <= dv_rm;
				end
				if (state_d == ipfi_pkg::S_DIV) k_q <= 2'd0;
			end
			ipfi_pkg::S_DIV: begin
				if (!div_go_q && dv_fin) begin
					n_q[k_q] <= n_q[k_q][NB-1] ? NB'(-dv_qt) : dv_qt;
					k_q <= k_q + 2'd1;
				end
				i_q <= '0;
			end
			ipfi_pkg::S_SEARCH: begin
				if (i_q == used_q) begin
					idx_q <= '0;
					st_q  <= ipfi_pkg::ST_FULL;
					first_neg_q <= axial_neg;
				end
			end
			ipfi_pkg::S_CHECK: begin
				if (hit) begin
					idx_q <= ipfi_pkg::IdxBits'(i_q);
					st_q  <= ipfi_pkg::ST_FOUND;
				end else begin
					i_q <= i_q + CNT'(1);
				end
			end
			ipfi_pkg::S_WR0: begin
				idx_q <= ipfi_pkg::IdxBits'(first_neg_q ? i_q + CNT'(1) : i_q);
				st_q  <= ipfi_pkg::ST_INSERTED;
				i_q   <= i_q + CNT'(1);
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/ipfi_ram.sv
// ----------------------------------------------------------------------------
// ipfi_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ipfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle at a single address; a write also reads out the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// File: src/ipfi_divu.sv
// ----------------------------------------------------------------------------
// ipfi_divu
// Radix-2 restoring divider for unsigned values, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ipfi_divu #(
	parameter int W = 36
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              busy,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  q_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  d_q;
	logic [W:0]    trial;

	assign trial     = {r_q, q_q[W-1]} - {1'b0, d_q};
	assign busy      = (cnt_q != '0);
	assign quotient  = q_q;
	assign remainder = r_q;

	// Shift one dividend bit into the partial remainder per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[W-2:0], q_q[W-1]};
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// File: src/ipfi_checker.sv
// ----------------------------------------------------------------------------
// ipfi_checker
// Port-level checks of the plane find-or-insert block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ipfi_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] status,
	input wire logic [9:0] plane_index
);

	// A result stalled at the output holds its status.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status))
		else $error("status changed while stalled");

	// Only one item is in flight: no input is taken while a result waits.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted with a result pending");

	// Degenerate and full results carry index zero.
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ipfi_pkg::ST_DEGENERATE || status == ipfi_pkg::ST_FULL)
		|-> plane_index == 10'd0)
		else $error("nonzero index on degenerate or full result");

	// An accepted item leaves the block busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting an item");

endmodule

bind integer_plane_find_or_insert ipfi_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.plane_index(plane_index)
);
`default_nettype wire

// File: tb/integer_plane_find_or_insert_tb.sv
// ----------------------------------------------------------------------------
// integer_plane_find_or_insert_tb
// Drives point triples into the plane table block and checks every result
// against a behavioral plane table kept in the testbench.
// ----------------------------------------------------------------------------
// Directed items cover degenerate triples, coordinate extremes, axial normals
// of both signs, repeated planes and twin hits. Half of the random items reuse a
// small pool of planes so that lookups hit; the rest are small-coordinate or
// full-range random triples that keep the table growing. Both channels idle in bursts.
`default_nettype none

// Scoreboard with its own copy of the plane table.
class plane_scoreboard;
	typedef struct {
		logic [9:0]  idx;
		logic [1:0]  st;
		logic [35:0] nx;
		logic [35:0] ny;
		logic [35:0] nz;
	} plane_result_t;

	longint tbl_nx[1024];
	longint tbl_ny[1024];
	longint tbl_nz[1024];
	longint tbl_ox[1024];
	longint tbl_oy[1024];
	longint tbl_oz[1024];
	int unsigned filled;
	plane_result_t pending[$];
	int errors;

	function new();
		filled = 0;
		errors = 0;
	endfunction

	function longint gcd64(longint p, longint q);
		longint t;
		if (p < 0) p = -p;
		if (q < 0) q = -q;
		while (q != 0) begin
			t = p % q;
			p = q;
			q = t;
		end
		return p;
	endfunction

	function void store(int unsigned i, longint x, longint y, longint z, longint o[3]);
		tbl_nx[i] = x;
		tbl_ny[i] = y;
		tbl_nz[i] = z;
		tbl_ox[i] = o[0];
		tbl_oy[i] = o[1];
		tbl_oz[i] = o[2];
	endfunction

	// Works out the expected result of one accepted item and updates the table.
	function void note_item(logic signed [15:0] p[9]);
		longint a[3], b[3], c[3], u[3], v[3], n[3];
		longint g, d;
		plane_result_t r;
		int nz_cnt;
		bit neg, hit;
		for (int k = 0; k < 3; k++) begin
			a[k] = p[k];
			b[k] = p[3+k];
			c[k] = p[6+k];
			u[k] = a[k] - b[k];
			v[k] = c[k] - b[k];
		end
		n[0] = u[1]*v[2] - u[2]*v[1];
		n[1] = u[2]*v[0] - u[0]*v[2];
		n[2] = u[0]*v[1] - u[1]*v[0];
		r.idx = '0;
		if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
			r.st = ipfi_pkg::ST_DEGENERATE;
		end else begin
			g = gcd64(gcd64(n[0], n[1]), n[2]);
			for (int k = 0; k < 3; k++) n[k] = n[k] / g;
			hit = 0;
			for (int unsigned i = 0; i < filled && !hit; i++) begin
				d = (a[0]-tbl_ox[i])*n[0] + (a[1]-tbl_oy[i])*n[1] + (a[2]-tbl_oz[i])*n[2];
				if (d == 0 && tbl_nx[i] == n[0] && tbl_ny[i] == n[1] && tbl_nz[i] == n[2]) begin
					hit = 1;
					r.idx = i[9:0];
				end
			end
			if (hit) begin
				r.st = ipfi_pkg::ST_FOUND;
			end else if (filled + 2 > 1024) begin
				r.st = ipfi_pkg::ST_FULL;
			end else begin
				r.st = ipfi_pkg::ST_INSERTED;
				nz_cnt = 0;
				neg = 0;
				for (int k = 0; k < 3; k++) begin
					if (n[k] != 0) nz_cnt++;
					if (n[k] < 0) neg = 1;
				end
				// A negative axial normal puts its positive twin first.
				if (nz_cnt == 1 && neg) begin
					store(filled, -n[0], -n[1], -n[2], a);
					store(filled + 1, n[0], n[1], n[2], a);
					r.idx = 10'(filled + 1);
				end else begin
					store(filled, n[0], n[1], n[2], a);
					store(filled + 1, -n[0], -n[1], -n[2], a);
					r.idx = 10'(filled);
				end
				filled += 2;
			end
		end
		r.nx = n[0][35:0];
		r.ny = n[1][35:0];
		r.nz = n[2][35:0];
		pending.push_back(r);
	endfunction

	// Compares one accepted result with the oldest expectation.
	function void check_result(plane_result_t got);
		plane_result_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result idx=%0d status=%0d", $time, got.idx, got.st);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.idx !== e.idx) begin
			$display("%0t: plane_index expected %0d actual %0d", $time, e.idx, got.idx);
			errors++;
		end
		if (got.st !== e.st) begin
			$display("%0t: status expected %0d actual %0d", $time, e.st, got.st);
			errors++;
		end
		if (got.nx !== e.nx) begin
			$display("%0t: reduced_nx expected %h actual %h", $time, e.nx, got.nx);
			errors++;
		end
		if (got.ny !== e.ny) begin
			$display("%0t: reduced_ny expected %h actual %h", $time, e.ny, got.ny);
			errors++;
		end
		if (got.nz !== e.nz) begin
			$display("%0t: reduced_nz expected %h actual %h", $time, e.nz, got.nz);
			errors++;
		end
	endfunction
endclass

module integer_plane_find_or_insert_tb;

	localparam int WatchdogLimit = 40000;
	localparam int RandomItems   = 480;
	localparam int CalmItems     = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] a_x = '0, a_y = '0, a_z = '0;
	logic signed [15:0] b_x = '0, b_y = '0, b_z = '0;
	logic signed [15:0] c_x = '0, c_y = '0, c_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ipfi_pkg::IdxBits-1:0] plane_index;
	logic [1:0] status;
	logic signed [ipfi_pkg::NormBits-1:0] reduced_nx, reduced_ny, reduced_nz;

	plane_scoreboard sb = new();
	bit calm = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	logic signed [15:0] pool[16][9];

	integer_plane_find_or_insert i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.plane_index(plane_index), .status(status),
		.reduced_nx(reduced_nx), .reduced_ny(reduced_ny), .reduced_nz(reduced_nz)
	);

	always #6 clk = ~clk;

	// Sends one item and waits until it is accepted; random gaps come first.
	task automatic send_points(logic signed [15:0] p[9]);
		int gap;
		if (!calm && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} =
			{p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]};
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_item(p);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_xyz(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz);
		logic signed [15:0] p[9];
		p = '{16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
			16'(cx), 16'(cy), 16'(cz)};
		send_points(p);
	endtask

	// Random coordinate with all bits exercised.
	function automatic logic signed [15:0] any_coord();
		return 16'($urandom);
	endfunction

	// Result side: random stall bursts and a check at every accepted result.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{plane_index, status, reduced_nx, reduced_ny, reduced_nz});
	end

	// Output stall bursts start at random while the bench is not calm.
	always @(negedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			out_stall  <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 4);
			out_stall  <= 1'b1;
		end
	end

	// Watchdog on cycles with no accepted item on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic signed [15:0] p[9];
		int sel, t;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: degenerate, extremes, axial signs, repeats and twins.
		send_xyz(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_xyz(1, 1, 1, 2, 2, 2, 3, 3, 3);
		send_xyz(1, 0, 0, 0, 0, 0, 0, 1, 0);
		send_xyz(0, 1, 0, 0, 0, 0, 1, 0, 0);
		send_xyz(5, 7, 0, 0, 0, 0, 3, -2, 0);
		send_xyz(0, 1, 0, 0, 0, 0, 1, 0, 0);
		send_xyz(0, 0, 9, 2, 0, 9, 0, 4, 9);
		send_xyz(0, 2, 0, 0, 0, 0, 0, 0, 2);
		send_xyz(0, 0, 2, 0, 0, 0, 0, 2, 0);
		send_xyz(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);
		send_xyz(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
		send_xyz(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
		send_xyz(-32768, -32768, 32767, -32768, 32767, 32767, 32767, 32767, 32767);
		send_xyz(3, 4, 5, 6, 8, 10, 12, 1, 7);
		send_xyz(6, 8, 10, 3, 4, 5, 12, 1, 7);
		send_xyz(-1, -1, -1, -1, -1, -1, 0, 0, 0);
		send_xyz(32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0);

		// Pause until the block has drained.
		wait (sb.pending.size() == 0);
		repeat (5) @(negedge clk);

		// Plane pool reused by half of the random items.
		for (int i = 0; i < 16; i++)
			for (int k = 0; k < 9; k++)
				pool[i][k] = (i < 8) ? 16'($urandom_range(0, 40) - 20) : any_coord();

		for (int n = 0; n < RandomItems; n++) begin
			if (n >= RandomItems - CalmItems) calm = 1;
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				// Same plane as a pool entry, sometimes with the first two points swapped.
				t = $urandom_range(0, 15);
				p = pool[t];
				if ($urandom_range(0, 1)) begin
					p[0] = pool[t][3]; p[1] = pool[t][4]; p[2] = pool[t][5];
					p[3] = pool[t][0]; p[4] = pool[t][1]; p[5] = pool[t][2];
				end
			end else if (sel < 6) begin
				for (int k = 0; k < 9; k++) p[k] = 16'($urandom_range(0, 6) - 3);
			end else begin
				for (int k = 0; k < 9; k++) p[k] = any_coord();
			end
			send_points(p);
		end

		calm = 1;
		wait (sb.pending.size() == 0);
		repeat (3000) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
